// ===== sv/clipped_blit_row_address_core_defines.svh =====
// Assertion macros shared by the row address core.
`ifndef CLIPPED_BLIT_ROW_ADDRESS_CORE_DEFINES_SVH
`define CLIPPED_BLIT_ROW_ADDRESS_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define CBRA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define CBRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/cbra_pkg.sv =====
// Constants and types of the clipped blit row address core.
package cbra_pkg;

    // Register and result field widths
    localparam int REG_W      = 20;
    localparam int OFF_W      = 42;
    localparam int CNT_W      = 22;
    localparam int ROW_W      = REG_W + 1;
    localparam int PROD_W     = ROW_W + REG_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int OUT_BITS   = OFF_W + OFF_W + CNT_W + REG_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [REG_W-1:0]     t_reg;

    // Register indexes
    localparam t_cfg_idx CFG_SRC_WIDTH  = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_SRC_HEIGHT = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_SRC_STRIDE = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_DST_WIDTH  = t_cfg_idx'(3);
    localparam t_cfg_idx CFG_DST_HEIGHT = t_cfg_idx'(4);
    localparam t_cfg_idx CFG_DST_STRIDE = t_cfg_idx'(5);

endpackage

// ===== sv/clipped_blit_row_address_core.sv =====
// Row address generator for a clipped rectangle copy between two images.
//
//  channel  | direction | handshake                      | payload
//  ---------+-----------+--------------------------------+-------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready  | rectangle and row index
//  m_axis   | out       | m_axis_tvalid / m_axis_tready  | offsets, byte count, rows
//  cfg      | in        | i_cfg_valid / o_cfg_ready      | register index and data
//
// Four register stages: source clip, destination clip, stride multiply, final
// offset add. One word enters per cycle while no stall has filled the stages.
// Reset clears the stage valid bits and the configuration registers.
// A stalled output holds its word and the stages behind it fill bubbles first,
// then stop; nothing is dropped or repeated. The config port is always ready.
`include "clipped_blit_row_address_core_defines.svh"

module clipped_blit_row_address_core
    import cbra_pkg::*;
#(
    parameter int COORD_BITS      = 21,
    parameter int BYTES_PER_PIXEL = 4,
    localparam int IN_BITS    = 6 * COORD_BITS + REG_W,
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // dst_x, dst_y, src_x, src_y, req_cols, req_rows, row_index (lowest first)
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // src_offset, dst_offset, byte_count, clipped_rows (lowest first)
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // row_valid
    output logic [0:0]             m_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [REG_W-1:0]       i_cfg_data
);

    localparam int CW = COORD_BITS;
    localparam int W  = ((CW > 21) ? CW : 21) + 2;
    localparam logic [3:0] BPP_V = 4'(BYTES_PER_PIXEL);

    // Configuration registers
    t_reg r_src_width, r_src_height, r_src_stride;
    t_reg r_dst_width, r_dst_height, r_dst_stride;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= '0;
            r_src_height <= '0;
            r_src_stride <= '0;
            r_dst_width  <= '0;
            r_dst_height <= '0;
            r_dst_stride <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data;
                CFG_SRC_HEIGHT: r_src_height <= i_cfg_data;
                CFG_SRC_STRIDE: r_src_stride <= i_cfg_data;
                CFG_DST_WIDTH:  r_dst_width  <= i_cfg_data;
                CFG_DST_HEIGHT: r_dst_height <= i_cfg_data;
                CFG_DST_STRIDE: r_dst_stride <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Bounds as signed values of the working width
    logic signed [W-1:0] sw_s, sh_s, dw_s, dh_s;
    assign sw_s = $signed({{(W-REG_W){1'b0}}, r_src_width});
    assign sh_s = $signed({{(W-REG_W){1'b0}}, r_src_height});
    assign dw_s = $signed({{(W-REG_W){1'b0}}, r_dst_width});
    assign dh_s = $signed({{(W-REG_W){1'b0}}, r_dst_height});

    // Stage handshake: a stage advances when it is empty or the next one advances
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;
    assign rdy4 = !r_v4 || m_axis_tready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign s_axis_tready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= s_axis_tvalid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // Unpack the input word and sign-extend the coordinates
    logic signed [W-1:0] in_dx, in_dy, in_sx, in_sy, in_cols, in_rows;
    t_reg in_row;
    assign in_dx   = $signed({{(W-CW){s_axis_tdata[1*CW-1]}}, s_axis_tdata[0*CW +: CW]});
    assign in_dy   = $signed({{(W-CW){s_axis_tdata[2*CW-1]}}, s_axis_tdata[1*CW +: CW]});
    assign in_sx   = $signed({{(W-CW){s_axis_tdata[3*CW-1]}}, s_axis_tdata[2*CW +: CW]});
    assign in_sy   = $signed({{(W-CW){s_axis_tdata[4*CW-1]}}, s_axis_tdata[3*CW +: CW]});
    assign in_cols = $signed({{(W-CW){s_axis_tdata[5*CW-1]}}, s_axis_tdata[4*CW +: CW]});
    assign in_rows = $signed({{(W-CW){s_axis_tdata[6*CW-1]}}, s_axis_tdata[5*CW +: CW]});
    assign in_row  = s_axis_tdata[6*CW +: REG_W];

    // ---------------- Stage 1: clip against the source ----------------
    logic signed [W-1:0] n1_xend, n1_sx, n1_cols_a, n1_cols;
    logic signed [W-1:0] n1_yend, n1_sy, n1_rows_a, n1_rows;
    logic                n1_ok;

    always_comb begin
        n1_xend   = in_sx + in_cols;
        n1_sx     = (in_sx < 0) ? '0 : in_sx;
        n1_cols_a = (in_sx < 0) ? in_cols + in_sx : in_cols;
        n1_cols   = (n1_xend > sw_s) ? sw_s - n1_sx : n1_cols_a;
        n1_yend   = in_sy + in_rows;
        n1_sy     = (in_sy < 0) ? '0 : in_sy;
        n1_rows_a = (in_sy < 0) ? in_rows + in_sy : in_rows;
        n1_rows   = (n1_yend > sh_s) ? sh_s - n1_sy : n1_rows_a;
        n1_ok     = !(n1_xend < 0) && !(n1_sx > sw_s) && (n1_cols_a > 0)
                    && !(in_dx > dw_s)
                    && !((n1_xend > sw_s) && (n1_cols < 0))
                    && !(n1_yend < 0) && !(n1_sy > sh_s) && (n1_rows_a > 0)
                    && !(in_dy > dh_s);
    end

    logic signed [W-1:0] r1_dx, r1_dy, r1_cols, r1_rows;
    t_reg                r1_sx, r1_sy, r1_row;
    logic                r1_ok;

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_dx   <= in_dx;
            r1_dy   <= in_dy;
            r1_cols <= n1_cols;
            r1_rows <= n1_rows;
            r1_sx   <= n1_sx[REG_W-1:0];
            r1_sy   <= n1_sy[REG_W-1:0];
            r1_row  <= in_row;
            r1_ok   <= n1_ok;
        end
    end

    // ---------------- Stage 2: clip against the destination ----------------
    logic signed [W-1:0] n2_dx, n2_cols_b, n2_cols, n2_dy, n2_rows_b, n2_rows;
    logic                n2_ok, n2_row_ok;
    logic [ROW_W-1:0]    n2_sy_row, n2_dy_row;

    always_comb begin
        n2_dx     = (r1_dx < 0) ? '0 : r1_dx;
        n2_cols_b = (r1_dx < 0) ? r1_cols + r1_dx : r1_cols;
        n2_cols   = (n2_dx + n2_cols_b > dw_s) ? dw_s - n2_dx : n2_cols_b;
        n2_dy     = (r1_dy < 0) ? '0 : r1_dy;
        n2_rows_b = (r1_dy < 0) ? r1_rows + r1_dy : r1_rows;
        n2_rows   = (n2_dy + n2_rows_b > dh_s) ? dh_s - n2_dy : n2_rows_b;
        n2_ok     = r1_ok && !(n2_rows < 0) && (n2_cols > 0);
        n2_row_ok = n2_ok && ($signed({{(W-REG_W){1'b0}}, r1_row}) < n2_rows);
        n2_sy_row = {1'b0, r1_sy} + {1'b0, r1_row};
        n2_dy_row = {1'b0, n2_dy[REG_W-1:0]} + {1'b0, r1_row};
    end

    logic [ROW_W-1:0] r2_sy_row, r2_dy_row;
    t_reg             r2_sx, r2_dx, r2_rows;
    logic [REG_W:0]   r2_cols;
    logic             r2_ok, r2_row_ok;

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_sy_row <= n2_sy_row;
            r2_dy_row <= n2_dy_row;
            r2_sx     <= r1_sx;
            r2_dx     <= n2_dx[REG_W-1:0];
            r2_rows   <= n2_rows[REG_W-1:0];
            r2_cols   <= n2_cols[REG_W:0];
            r2_ok     <= n2_ok;
            r2_row_ok <= n2_row_ok;
        end
    end

    // ---------------- Stage 3: row times stride ----------------
    logic [PROD_W-1:0] r3_so_prod, r3_do_prod;
    t_reg              r3_sx, r3_dx, r3_rows;
    logic [REG_W:0]    r3_cols;
    logic              r3_ok, r3_row_ok;

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r3_so_prod <= PROD_W'(r2_sy_row) * PROD_W'(r_src_stride);
            r3_do_prod <= PROD_W'(r2_dy_row) * PROD_W'(r_dst_stride);
            r3_sx      <= r2_sx;
            r3_dx      <= r2_dx;
            r3_rows    <= r2_rows;
            r3_cols    <= r2_cols;
            r3_ok      <= r2_ok;
            r3_row_ok  <= r2_row_ok;
        end
    end

    // ---------------- Stage 4: add column, scale to bytes, blank ----------------
    logic [SUM_W-1:0]   n4_so_sum, n4_do_sum;
    logic [SUM_W+3:0]   n4_so_full, n4_do_full;
    logic [REG_W+4:0]   n4_cnt_full;
    logic [OFF_W-1:0]   n4_src_off, n4_dst_off;
    logic [CNT_W-1:0]   n4_cnt;
    t_reg               n4_rows;

    always_comb begin
        n4_so_sum   = {1'b0, r3_so_prod} + SUM_W'(r3_sx);
        n4_do_sum   = {1'b0, r3_do_prod} + SUM_W'(r3_dx);
        n4_so_full  = (SUM_W+4)'(n4_so_sum) * (SUM_W+4)'(BPP_V);
        n4_do_full  = (SUM_W+4)'(n4_do_sum) * (SUM_W+4)'(BPP_V);
        n4_cnt_full = (REG_W+5)'(r3_cols) * (REG_W+5)'(BPP_V);
        n4_src_off  = r3_row_ok ? n4_so_full[OFF_W-1:0] : '0;
        n4_dst_off  = r3_row_ok ? n4_do_full[OFF_W-1:0] : '0;
        n4_cnt      = r3_row_ok ? n4_cnt_full[CNT_W-1:0] : '0;
        n4_rows     = r3_ok ? r3_rows : '0;
    end

    logic [OFF_W-1:0] r4_src_off, r4_dst_off;
    logic [CNT_W-1:0] r4_cnt;
    t_reg             r4_rows;
    logic             r4_row_ok;

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r4_src_off <= n4_src_off;
            r4_dst_off <= n4_dst_off;
            r4_cnt     <= n4_cnt;
            r4_rows    <= n4_rows;
            r4_row_ok  <= r3_row_ok;
        end
    end

    // Drive the output word
    assign m_axis_tvalid = r_v4;
    assign m_axis_tuser  = r4_row_ok;
    assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_BITS){1'b0}},
                            r4_rows, r4_cnt, r4_dst_off, r4_src_off};

    // ---------------- Assertions ----------------
    `CBRA_ASSERT_NOW(a_valid_row_has_rows, i_clk, i_rst_n,
        m_axis_tvalid && r4_row_ok, r4_rows != '0,
        "valid row reported with zero clipped rows")
    `CBRA_ASSERT_NOW(a_blank_invalid_row, i_clk, i_rst_n,
        m_axis_tvalid && !r4_row_ok,
        (r4_src_off == '0) && (r4_dst_off == '0) && (r4_cnt == '0),
        "invalid row carries nonzero offsets or count")
    `CBRA_ASSERT_NOW(a_full_pipe_blocks_input, i_clk, i_rst_n,
        r_v1 && r_v2 && r_v3 && r_v4 && !m_axis_tready, !s_axis_tready,
        "input accepted while every stage is full and stalled")

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the clipped blit row address core.
`timescale 1ns / 100ps

module testbench;
    import cbra_pkg::*;

    localparam int  COORD_W      = 21;
    localparam int  BYTES_PER_PX = 4;
    localparam int  REQ_BITS     = 6 * COORD_W + REG_W;
    localparam int  REQ_TDATA_W  = ((REQ_BITS + 7) / 8) * 8;
    localparam longint COORD_MIN = -(64'sd1 <<< (COORD_W - 1));
    localparam longint COORD_MAX = (64'sd1 <<< (COORD_W - 1)) - 1;
    localparam int  REG_MAX      = (1 << REG_W) - 1;
    localparam int  NUM_SETTINGS = 10;
    localparam int  DRAIN_CYCLES = 8;

    // One row request, packed lowest field last so the vector matches tdata
    typedef struct packed {
        logic [REG_W-1:0]   row_index;
        logic [COORD_W-1:0] req_rows;
        logic [COORD_W-1:0] req_cols;
        logic [COORD_W-1:0] src_y;
        logic [COORD_W-1:0] src_x;
        logic [COORD_W-1:0] dst_y;
        logic [COORD_W-1:0] dst_x;
    } rect_req_t;

    // One row address word, row_valid on top so it lines up with {tuser, tdata}
    typedef struct packed {
        logic             row_valid;
        logic [REG_W-1:0] clipped_rows;
        logic [CNT_W-1:0] byte_count;
        logic [OFF_W-1:0] dst_offset;
        logic [OFF_W-1:0] src_offset;
    } row_addr_t;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic [REQ_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    t_cfg_idx               i_cfg_index   = CFG_SRC_WIDTH;
    t_reg                   i_cfg_data    = '0;

    // Geometry as the block should hold it
    longint src_w, src_h, src_pitch, dst_w, dst_h, dst_pitch;

    rect_req_t queued_rects[$];
    row_addr_t awaited_rows[$];
    rect_req_t held_rect;

    int send_idle_pct = 27;
    int recv_idle_pct = 78;
    int mismatch_count = 0;
    int words_sent = 0;
    int rows_checked = 0;
    int rows_valid = 0;
    int rows_rejected = 0;

    clipped_blit_row_address_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Clip the rectangle and work out the row addresses
    function automatic row_addr_t predict_row_addr(rect_req_t r);
        longint    dx, dy, sx, sy, cols, rows, xend, yend, row, so, dof, nbytes;
        bit        ok;
        row_addr_t res;
        res  = '0;
        dx   = $signed(r.dst_x);
        dy   = $signed(r.dst_y);
        sx   = $signed(r.src_x);
        sy   = $signed(r.src_y);
        cols = $signed(r.req_cols);
        rows = $signed(r.req_rows);
        row  = longint'(r.row_index);
        ok   = 1'b1;

        // source columns
        xend = sx + cols;
        if (sx < 0) begin
            cols += sx;
            sx = 0;
        end
        if (xend < 0 || sx > src_w || cols <= 0 || dx > dst_w)
            ok = 1'b0;
        if (ok && xend > src_w) begin
            cols = src_w - sx;
            if (cols < 0)
                ok = 1'b0;
        end
        // source rows
        if (ok) begin
            yend = sy + rows;
            if (sy < 0) begin
                rows += sy;
                sy = 0;
            end
            if (yend < 0 || sy > src_h || rows <= 0 || dy > dst_h)
                ok = 1'b0;
            if (ok && yend > src_h)
                rows = src_h - sy;
        end
        // destination edges
        if (ok) begin
            if (dx < 0) begin
                cols += dx;
                dx = 0;
            end
            if (dx + cols > dst_w)
                cols = dst_w - dx;
            if (dy < 0) begin
                rows += dy;
                dy = 0;
            end
            if (dy + rows > dst_h)
                rows = dst_h - dy;
            if (rows < 0 || cols <= 0)
                ok = 1'b0;
        end
        if (!ok)
            return res;

        res.clipped_rows = rows[REG_W-1:0];
        if (row < rows) begin
            so     = ((sy + row) * src_pitch + sx) * BYTES_PER_PX;
            dof    = ((dy + row) * dst_pitch + dx) * BYTES_PER_PX;
            nbytes = cols * BYTES_PER_PX;
            res.row_valid  = 1'b1;
            res.src_offset = so[OFF_W-1:0];
            res.dst_offset = dof[OFF_W-1:0];
            res.byte_count = nbytes[CNT_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(longint lo, longint hi);
        longint v;
        if (lo < COORD_MIN) lo = COORD_MIN;
        if (hi > COORD_MAX) hi = COORD_MAX;
        if (hi < lo) hi = lo;
        v = lo + longint'($urandom_range(32'(hi - lo)));
        return v[COORD_W-1:0];
    endfunction

    function automatic rect_req_t mk_rect(int dx, int dy, int sx, int sy, int cols, int rows,
                                          int row);
        rect_req_t r;
        r.dst_x     = COORD_W'(dx);
        r.dst_y     = COORD_W'(dy);
        r.src_x     = COORD_W'(sx);
        r.src_y     = COORD_W'(sy);
        r.req_cols  = COORD_W'(cols);
        r.req_rows  = COORD_W'(rows);
        r.row_index = REG_W'(row);
        return r;
    endfunction

    // Mostly rectangles near the images, some pure noise
    function automatic rect_req_t random_rect();
        rect_req_t r;
        row_addr_t probe;
        longint    span_x, span_y;
        int        lim;
        if ($urandom_range(99) < 15) begin
            r = REQ_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom});
            return r;
        end
        span_x      = (src_w > dst_w) ? src_w : dst_w;
        span_y      = (src_h > dst_h) ? src_h : dst_h;
        r.src_x     = pick_coord(-src_w / 4 - 3, src_w + 3);
        r.src_y     = pick_coord(-src_h / 4 - 3, src_h + 3);
        r.dst_x     = pick_coord(-dst_w / 4 - 3, dst_w + 3);
        r.dst_y     = pick_coord(-dst_h / 4 - 3, dst_h + 3);
        r.req_cols  = pick_coord(-3, span_x + 6);
        r.req_rows  = pick_coord(-3, span_y + 6);
        r.row_index = '0;
        probe = predict_row_addr(r);
        if ($urandom_range(99) < 85) begin
            lim = int'(probe.clipped_rows) + 2;
            if (lim > REG_MAX) lim = REG_MAX;
            r.row_index = REG_W'($urandom_range(lim));
        end else begin
            r.row_index = REG_W'($urandom);
        end
        return r;
    endfunction

    function automatic t_reg random_reg();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10) return '0;
        if (roll < 20) return t_reg'(REG_MAX);
        if (roll < 40) return t_reg'($urandom);
        return t_reg'($urandom_range(300, 1));
    endfunction

    task automatic write_reg(t_cfg_idx idx, t_reg val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SRC_WIDTH:  src_w     = longint'(val);
            CFG_SRC_HEIGHT: src_h     = longint'(val);
            CFG_SRC_STRIDE: src_pitch = longint'(val);
            CFG_DST_WIDTH:  dst_w     = longint'(val);
            CFG_DST_HEIGHT: dst_h     = longint'(val);
            CFG_DST_STRIDE: dst_pitch = longint'(val);
            default: ;
        endcase
    endtask

    task automatic set_geometry(t_reg sw, t_reg sh, t_reg sp, t_reg dw, t_reg dh, t_reg dp);
        write_reg(CFG_SRC_WIDTH, sw);
        write_reg(CFG_SRC_HEIGHT, sh);
        write_reg(CFG_SRC_STRIDE, sp);
        write_reg(CFG_DST_WIDTH, dw);
        write_reg(CFG_DST_HEIGHT, dh);
        write_reg(CFG_DST_STRIDE, dp);
    endtask

    // Hold until every queued word went out and every row came back
    task automatic wait_idle();
        @(negedge i_clk);
        while (queued_rects.size() > 0 || s_axis_tvalid || awaited_rows.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    // Request driver: present queued words, predict each one as it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                awaited_rows.push_back(predict_row_addr(held_rect));
                words_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (queued_rects.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    held_rect = queued_rects.pop_front();
                    s_axis_tdata  <= REQ_TDATA_W'(held_rect);
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Row monitor: check each taken word against the oldest prediction
    always @(posedge i_clk) begin
        row_addr_t got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tuser, m_axis_tdata[OUT_BITS-1:0]};
                if (awaited_rows.size() == 0) begin
                    $error("row word with no request pending");
                    mismatch_count++;
                end else begin
                    want = awaited_rows.pop_front();
                    compare_field("row_valid", 64'(want.row_valid), 64'(got.row_valid));
                    compare_field("src_offset", 64'(want.src_offset), 64'(got.src_offset));
                    compare_field("dst_offset", 64'(want.dst_offset), 64'(got.dst_offset));
                    compare_field("byte_count", 64'(want.byte_count), 64'(got.byte_count));
                    compare_field("clipped_rows", 64'(want.clipped_rows),
                                  64'(got.clipped_rows));
                    rows_checked++;
                    if (want.row_valid)
                        rows_valid++;
                    else if (want.clipped_rows == 0)
                        rows_rejected++;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Stimulus: one batch of rows per register setting
    initial begin
        int n_random;
        int spins;
        src_w = 0; src_h = 0; src_pitch = 0;
        dst_w = 0; dst_h = 0; dst_pitch = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int setting = 0; setting < NUM_SETTINGS; setting++) begin
            wait_idle();
            if (setting == 4) begin
                send_idle_pct = 78;
                recv_idle_pct = 27;
            end else if (setting == 7) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            n_random = 50;
            case (setting)
                0: n_random = 10;   // registers as left by reset
                1: begin
                    set_geometry(64, 48, 80, 100, 60, 128);
                    queued_rects.push_back(mk_rect(5, 6, 3, 4, 10, 8, 2));     // interior
                    queued_rects.push_back(mk_rect(5, 6, 3, 4, 10, 8, 7));     // last row
                    queued_rects.push_back(mk_rect(5, 6, 3, 4, 10, 8, 8));     // row past end
                    queued_rects.push_back(mk_rect(5, 6, -5, 4, 10, 8, 0));    // source left clip
                    queued_rects.push_back(mk_rect(5, 6, -20, 4, 10, 8, 0));   // source x end < 0
                    queued_rects.push_back(mk_rect(5, 6, 65, 4, 10, 8, 0));    // past source width
                    queued_rects.push_back(mk_rect(5, 6, 64, 4, 10, 8, 0));    // on source width
                    queued_rects.push_back(mk_rect(5, 6, 3, 4, 0, 8, 0));      // no columns
                    queued_rects.push_back(mk_rect(101, 6, 3, 4, 10, 8, 0));   // past dest width
                    queued_rects.push_back(mk_rect(5, 6, 60, 4, 20, 8, 1));    // source right clip
                    queued_rects.push_back(mk_rect(5, 6, 3, -3, 10, 8, 0));    // source top clip
                    queued_rects.push_back(mk_rect(5, 6, 3, -9, 10, 8, 0));    // source y end < 0
                    queued_rects.push_back(mk_rect(5, 6, 3, 49, 10, 8, 0));    // past source height
                    queued_rects.push_back(mk_rect(5, 6, 3, 4, 10, 0, 0));     // no rows
                    queued_rects.push_back(mk_rect(5, 61, 3, 4, 10, 8, 0));    // past dest height
                    queued_rects.push_back(mk_rect(5, 6, 3, 45, 10, 10, 2));   // source bottom clip
                    queued_rects.push_back(mk_rect(-3, 6, 3, 4, 10, 8, 0));    // dest left clip
                    queued_rects.push_back(mk_rect(95, 6, 3, 4, 20, 8, 0));    // dest right clip
                    queued_rects.push_back(mk_rect(5, -2, 3, 4, 10, 8, 0));    // dest top clip
                    queued_rects.push_back(mk_rect(5, 58, 3, 4, 10, 10, 1));   // dest bottom clip
                    queued_rects.push_back(mk_rect(5, -8, 3, 4, 10, 8, 0));    // zero rows left
                    queued_rects.push_back(mk_rect(5, -9, 3, 4, 10, 8, 0));    // negative rows
                    queued_rects.push_back(mk_rect(int'(COORD_MIN), int'(COORD_MIN),
                        int'(COORD_MIN), int'(COORD_MIN), int'(COORD_MIN), int'(COORD_MIN), 0));
                    queued_rects.push_back(mk_rect(int'(COORD_MAX), int'(COORD_MAX),
                        int'(COORD_MAX), int'(COORD_MAX), int'(COORD_MAX), int'(COORD_MAX),
                        REG_MAX));
                    n_random = 40;
                end
                2: begin
                    set_geometry(REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX);
                    // widest rows and offsets near the top of the offset width
                    queued_rects.push_back(mk_rect(0, 0, 0, 0, int'(COORD_MAX), int'(COORD_MAX),
                                                   REG_MAX - 1));
                    queued_rects.push_back(mk_rect(REG_MAX, REG_MAX, REG_MAX - 1, REG_MAX - 1,
                                                   1, 1, 0));
                    n_random = 48;
                end
                3: set_geometry(1, REG_MAX, 0, REG_MAX, 1, REG_MAX);
                default: set_geometry(random_reg(), random_reg(), random_reg(),
                                      random_reg(), random_reg(), random_reg());
            endcase
            for (int k = 0; k < n_random; k++)
                queued_rects.push_back(random_rect());
        end

        // Drain: wait for the sender, then give the results a bounded time
        @(negedge i_clk);
        while (queued_rects.size() > 0 || s_axis_tvalid)
            @(negedge i_clk);
        spins = 0;
        while (awaited_rows.size() > 0 && spins < 2000) begin
            @(negedge i_clk);
            spins++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (awaited_rows.size() > 0) begin
            $error("%0d row words never arrived", awaited_rows.size());
            mismatch_count++;
        end

        $display("Sent %0d row requests over %0d register settings, checked %0d words:",
                 words_sent, NUM_SETTINGS, rows_checked);
        $display("  %0d valid rows, %0d rejected copies, %0d rows outside the clip",
                 rows_valid, rows_rejected, rows_checked - rows_valid - rows_rejected);
        if (mismatch_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/cbra_pkg.sv
sv/clipped_blit_row_address_core.sv
bench/testbench.sv
